// ===== rtl/core/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

  localparam int unsigned IDX_BITS    = 4;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 40;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned REQ_W       = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_A = 2'd0,
    REQ_WR_B = 2'd1,
    REQ_RD   = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESULT_ROWS = 2'd0,
    CFG_INNER_SIZE  = 2'd1,
    CFG_RESULT_COLS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } mme_state_e;

  typedef struct packed {
    logic                start;
    logic                range_err;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } rd_cmd_t;

endpackage

// ===== rtl/core/mme_if.sv =====
// Handshake channel interfaces: requests, results and register writes.
interface mme_req_if;
  import mme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [IDX_BITS-1:0]      row_index;
  logic [IDX_BITS-1:0]      col_index;
  logic signed [ELEM_W-1:0] elem_value;
  modport source (output valid, req_type, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, req_type, row_index, col_index, elem_value, output ready);
endinterface

interface mme_rsp_if;
  import mme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product_value;
  logic                     index_error;
  modport source (output valid, product_value, index_error, input ready);
  modport sink   (input valid, product_value, index_error, output ready);
endinterface

interface mme_cfg_if;
  import mme_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mme_elem_store.sv =====
// Element store: one write port, one read port with registered read data.
module mme_elem_store #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/mme_dot_seq.sv =====
// Dot product sequencer: walks k over both stores, multiplies and accumulates.
module mme_dot_seq #(
  parameter int unsigned MAX_DIM   = 16,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mme_pkg::rd_cmd_t                  cmd_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]      nk_i,
  output logic                              idle_o,
  output logic [2*$clog2(MAX_DIM)-1:0]      a_addr_o,
  output logic [2*$clog2(MAX_DIM)-1:0]      b_addr_o,
  input  logic [ELEM_BITS-1:0]              a_data_i,
  input  logic [ELEM_BITS-1:0]              b_data_i,
  mme_rsp_if.source                         rsp_o
);
  import mme_pkg::*;

  localparam int unsigned IW = $clog2(MAX_DIM);
  localparam int unsigned KW = $clog2(MAX_DIM+1);

  mme_state_e                 state_q, state_d;
  logic [KW-1:0]              issue_cnt_q, issue_cnt_d;
  logic [KW-1:0]              acc_cnt_q, acc_cnt_d;
  logic [IDX_BITS-1:0]        row_q, row_d, col_q, col_d;
  logic                       err_q, err_d;
  logic signed [PROD_W-1:0]   acc_q, acc_d;
  logic                       rd_v_q, prod_v_q;
  logic signed [2*ELEM_BITS-1:0] prod_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [PROD_W-1:0]   out_value_q, out_value_d;
  logic                       out_err_q, out_err_d;
  logic                       issue, out_free;

  assign issue    = (state_q == ST_RUN) && (issue_cnt_q < nk_i);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign a_addr_o = {IW'(row_q), issue_cnt_q[IW-1:0]};
  assign b_addr_o = {issue_cnt_q[IW-1:0], IW'(col_q)};
  assign idle_o   = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    acc_cnt_d   = acc_cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    err_d       = err_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          row_d       = cmd_i.row;
          col_d       = cmd_i.col;
          err_d       = cmd_i.range_err;
          acc_d       = '0;
          issue_cnt_d = '0;
          acc_cnt_d   = '0;
          if (cmd_i.range_err || (nk_i == '0)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          issue_cnt_d = KW'(issue_cnt_q + KW'(1));
        end
        if (prod_v_q) begin
          acc_d     = acc_q + PROD_W'(prod_q);
          acc_cnt_d = KW'(acc_cnt_q + KW'(1));
          if (KW'(acc_cnt_q + KW'(1)) == nk_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = acc_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_cnt_q <= '0;
      acc_cnt_q   <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      acc_cnt_q   <= acc_cnt_d;
      rd_v_q      <= issue;
      prod_v_q    <= rd_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    err_q       <= err_d;
    acc_q       <= acc_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
    if (rd_v_q) begin
      prod_q <= $signed(a_data_i) * $signed(b_data_i);
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.product_value = out_value_q;
  assign rsp_o.index_error   = out_err_q;

endmodule

// ===== rtl/core/matrix_multiply_engine_core.sv =====
// Matrix multiply engine top level: register file, request decode, stores and sequencer.
//
//  channel  dir  modport  transfer carries
//  req_i    in   sink     req_type, row_index, col_index, elem_value
//  rsp_o    out  source   product_value, index_error (one per read request)
//  cfg_i    in   sink     index, data (result_rows, inner_size, result_cols)
//
// An in-range read does one multiply-accumulate per cycle, fed by the single read port
// of each store. An out-of-range read, or one with inner_size zero, goes straight to
// the finish state and issues no store reads.
// rst_ni clears control state, sets the dimension registers to 16; stores are not cleared.
// A finished result waits in the output register; write requests are still taken meanwhile.
module matrix_multiply_engine_core #(
  parameter int unsigned MAX_DIM   = 16,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mme_req_if.sink    req_i,
  mme_rsp_if.source  rsp_o,
  mme_cfg_if.sink    cfg_i
);
  import mme_pkg::*;

  localparam int unsigned IW = $clog2(MAX_DIM);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned KW = $clog2(MAX_DIM+1);

  logic [CFG_W-1:0]     rows_q, inner_q, cols_q;
  logic [KW-1:0]        nr, nk, nc;
  logic                 seq_idle, req_acc;
  logic                 row_in_r, row_in_k, col_in_k, col_in_c;
  logic                 a_we, b_we;
  logic [AW-1:0]        wr_addr, a_rd_addr, b_rd_addr;
  logic [ELEM_BITS-1:0] wr_data, a_rd_data, b_rd_data;
  rd_cmd_t              cmd;

  function automatic logic [KW-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [KW-1:0] res;
    if (32'(r) > MAX_DIM) res = KW'(MAX_DIM);
    else                  res = KW'(r);
    return res;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_W'(16);
      inner_q <= CFG_W'(16);
      cols_q  <= CFG_W'(16);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_RESULT_ROWS: rows_q  <= cfg_i.data;
        CFG_INNER_SIZE:  inner_q <= cfg_i.data;
        CFG_RESULT_COLS: cols_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign nr = eff_dim(rows_q);
  assign nk = eff_dim(inner_q);
  assign nc = eff_dim(cols_q);

  assign req_i.ready = seq_idle;
  assign req_acc     = req_i.valid && seq_idle;

  assign row_in_r = 32'(req_i.row_index) < 32'(nr);
  assign row_in_k = 32'(req_i.row_index) < 32'(nk);
  assign col_in_k = 32'(req_i.col_index) < 32'(nk);
  assign col_in_c = 32'(req_i.col_index) < 32'(nc);

  always_comb begin
    a_we          = 1'b0;
    b_we          = 1'b0;
    cmd.start     = 1'b0;
    cmd.range_err = !(row_in_r && col_in_c);
    cmd.row       = req_i.row_index;
    cmd.col       = req_i.col_index;
    unique case (req_i.req_type)
      REQ_WR_A: a_we      = req_acc && row_in_r && col_in_k;
      REQ_WR_B: b_we      = req_acc && row_in_k && col_in_c;
      REQ_RD:   cmd.start = req_acc;
      default: ;
    endcase
  end

  assign wr_addr = {IW'(req_i.row_index), IW'(req_i.col_index)};
  assign wr_data = ELEM_BITS'($unsigned(req_i.elem_value));

  mme_elem_store #(.AW(AW), .DW(ELEM_BITS)) u_store_a (
    .clk_i     (clk_i),
    .we_i      (a_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (a_rd_addr),
    .rd_data_o (a_rd_data)
  );

  mme_elem_store #(.AW(AW), .DW(ELEM_BITS)) u_store_b (
    .clk_i     (clk_i),
    .we_i      (b_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (b_rd_addr),
    .rd_data_o (b_rd_data)
  );

  mme_dot_seq #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dot_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .nk_i     (nk),
    .idle_o   (seq_idle),
    .a_addr_o (a_rd_addr),
    .b_addr_o (b_rd_addr),
    .a_data_i (a_rd_data),
    .b_data_i (b_rd_data),
    .rsp_o    (rsp_o)
  );

  // stores are only written while no dot product is in flight
  a_no_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_idle |-> !(a_we || b_we))
    else $error("store write during dot product");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.index_error |-> rsp_o.product_value == '0)
    else $error("index error with non-zero value");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start && !cmd.range_err && (nk != '0) |=> !seq_idle ##1 !seq_idle)
    else $error("in-range read finished too early");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !req_i.ready)
    else $error("request taken while read pending");

endmodule
